/* src/mscc_pkg.sv */
// Shared types and constants for the marching-squares cell contour block.
package mscc_pkg;

   localparam int GridSize = 4096;
   localparam int CoordW   = 12;
   localparam int ValW     = 24;
   localparam int PosW     = 29;
   localparam int SizeW    = 16;
   localparam int TW       = 17;
   localparam int QDepth   = 2;

   localparam logic [1:0] KindMove  = 2'd0;
   localparam logic [1:0] KindLine  = 2'd1;
   localparam logic [1:0] KindClose = 2'd2;

   localparam logic CsrWidth  = 1'b0;
   localparam logic CsrHeight = 1'b1;

   localparam logic [CoordW-1:0] GridLimit = CoordW'(GridSize - 1);

   // Classified cell handed from front to back
   typedef struct packed {
      logic [CoordW-1:0]  cx;
      logic [CoordW-1:0]  cy;
      logic [3:0][ValW-1:0] v;
      logic [3:0]         mask;
      logic               emit_move;
      logic               active;
      logic               frame_end;
   } job_type;

   typedef enum logic [2:0] {
      BkIdle, BkOrigin, BkMove, BkDiv, BkScale, BkEmit, BkClose
   } bk_state_type;

endpackage

/* src/mscc_front.sv */
// Front end: accept cells, classify corners, track the path flag, queue jobs.
module mscc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [mscc_pkg::CoordW-1:0]  req_cell_x,
   input  logic [mscc_pkg::CoordW-1:0]  req_cell_y,
   input  logic signed [mscc_pkg::ValW-1:0] req_v_top_left,
   input  logic signed [mscc_pkg::ValW-1:0] req_v_top_right,
   input  logic signed [mscc_pkg::ValW-1:0] req_v_bottom_right,
   input  logic signed [mscc_pkg::ValW-1:0] req_v_bottom_left,
   input  logic                         req_frame_start,
   input  logic                         req_frame_end,
   output logic                         job_valid,
   output mscc_pkg::job_type            job,
   input  logic                         job_pop
);
   mscc_pkg::job_type q_ff [mscc_pkg::QDepth];
   logic [1:0] count_ff, count_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       started_ff, started_in;
   logic       accept;
   logic [3:0] mask;
   logic       mixed, active, started_eff;
   mscc_pkg::job_type newjob;

   assign req_stall = (count_ff == 2'(mscc_pkg::QDepth));
   assign accept    = req_valid && !req_stall;

   // Classify the incoming cell
   always_comb begin
      mask = {req_v_bottom_left[mscc_pkg::ValW-1], req_v_bottom_right[mscc_pkg::ValW-1],
              req_v_top_right[mscc_pkg::ValW-1], req_v_top_left[mscc_pkg::ValW-1]};
      mixed  = (mask != 4'h0) && (mask != 4'hF);
      active = mixed && (req_cell_x < mscc_pkg::GridLimit)
                     && (req_cell_y < mscc_pkg::GridLimit);
      started_eff = started_ff && !req_frame_start;
      newjob.cx = req_cell_x;
      newjob.cy = req_cell_y;
      newjob.v  = {req_v_bottom_left, req_v_bottom_right, req_v_top_right, req_v_top_left};
      newjob.mask = mask;
      newjob.emit_move = active && !started_eff;
      newjob.active = active;
      newjob.frame_end = req_frame_end;
      started_in = accept ? (started_eff || active) : started_ff;
   end

   // Advance queue pointers
   always_comb begin
      wr_in = accept ? !wr_ff : wr_ff;
      rd_in = job_pop ? !rd_ff : rd_ff;
      count_in = count_ff + 2'(accept) - 2'(job_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; rd_ff <= 1'b0; wr_ff <= 1'b0; started_ff <= 1'b0;
      end else begin
         count_ff <= count_in; rd_ff <= rd_in; wr_ff <= wr_in; started_ff <= started_in;
      end
      if (accept) q_ff[wr_ff] <= newjob;
   end

   assign job_valid = (count_ff != 2'd0);
   assign job       = q_ff[rd_ff];

   property p_no_overflow;
      @(posedge clock) disable iff (reset) count_ff == 2'(mscc_pkg::QDepth) |-> !accept;
   endproperty
   a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");
   property p_no_underflow;
      @(posedge clock) disable iff (reset) job_pop |-> job_valid;
   endproperty
   a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");
   property p_count;
      @(posedge clock) disable iff (reset) count_ff <= 2'(mscc_pkg::QDepth);
   endproperty
   a_count: assert property (p_count) else $error("queue count out of range");
endmodule

/* src/mscc_div.sv */
// Restoring divider: quotient of num<<16 by den, 16 bits, one bit a cycle.
module mscc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [24:0] num,
   input  logic [24:0] den,
   output logic        done,
   output logic [15:0] quo
);
   logic [25:0] rem_ff, rem_in;
   logic [15:0] q_ff, q_in;
   logic [24:0] den_ff;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [25:0] trial;

   // One quotient bit per step; num < den so 16 steps suffice
   always_comb begin
      trial = {rem_ff[24:0], 1'b0} - {1'b0, den_ff};
      rem_in = rem_ff; q_in = q_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      if (start) begin
         rem_in = {1'b0, num}; q_in = '0; cnt_in = 5'd16; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[25]) begin
            rem_in = trial; q_in = {q_ff[14:0], 1'b1};
         end else begin
            rem_in = {rem_ff[24:0], 1'b0}; q_in = {q_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         busy_in = (cnt_ff != 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; q_ff <= q_in;
      if (start) den_ff <= den;
   end

   assign done = busy_ff && (cnt_ff == 5'd1);
   assign quo  = {q_ff[14:0], !trial[25]};
endmodule

/* src/mscc_back.sv */
// Back end: compute points for one queued cell and drive the result channel.
module mscc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   input  mscc_pkg::job_type           job,
   output logic                        job_pop,
   input  logic [mscc_pkg::SizeW-1:0]  cell_width,
   input  logic [mscc_pkg::SizeW-1:0]  cell_height,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_point_kind,
   output logic [mscc_pkg::PosW-1:0]   rsp_x_pos,
   output logic [mscc_pkg::PosW-1:0]   rsp_y_pos,
   output logic                        rsp_last
);
   mscc_pkg::bk_state_type st_ff, st_in;
   logic [1:0]  idx_ff, idx_in;
   logic [3:0]  left_ff, left_in;
   logic [mscc_pkg::PosW-1:0] tx_ff, ty_ff;
   logic [mscc_pkg::TW-1:0]   t_ff;
   logic [mscc_pkg::SizeW-1:0] off_ff;
   logic        div_start, div_done;
   logic [15:0] div_q;
   logic signed [mscc_pkg::ValW:0] a, b, diff, num;
   logic        t_direct;
   logic [mscc_pkg::TW-1:0] t_fix;
   logic [mscc_pkg::SizeW-1:0] size;
   logic [32:0] prod;
   logic [3:0]  rest;
   logic        fire;
   logic [1:0]  kind;
   logic [mscc_pkg::PosW-1:0] xo, yo;
   logic        lst;
   logic        div_busy_q, div_busy_ff, div_busy_in;

   assign fire = rsp_valid && !rsp_stall;

   // Edge operands for the current corner
   always_comb begin
      a = (mscc_pkg::ValW+1)'(signed'(job.v[idx_ff]));
      b = (mscc_pkg::ValW+1)'(signed'(job.v[idx_ff + 2'd1]));
      diff = b - a;
      num = -a;
      t_direct = 1'b1;
      t_fix = '0;
      if (diff == 0) t_fix = 17'd32768;
      else if (diff < 0) t_fix = '0;
      else if (num <= 0) t_fix = '0;
      else if (num >= diff) t_fix = 17'd65536;
      else t_direct = 1'b0;
      size = idx_ff[0] ? cell_height : cell_width;
      prod = 33'(t_ff) * 33'(size);
      rest = left_ff & ~(4'b1 << idx_ff);
   end

   // Next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         mscc_pkg::BkIdle:   if (job_valid) st_in = mscc_pkg::BkOrigin;
         mscc_pkg::BkOrigin: begin
            if (!job.active) st_in = job.frame_end ? mscc_pkg::BkClose : mscc_pkg::BkIdle;
            else if (job.emit_move) st_in = mscc_pkg::BkMove;
            else st_in = mscc_pkg::BkDiv;
         end
         mscc_pkg::BkMove:   if (fire) st_in = mscc_pkg::BkDiv;
         mscc_pkg::BkDiv:    if (t_direct || div_done) st_in = mscc_pkg::BkScale;
         mscc_pkg::BkScale:  st_in = mscc_pkg::BkEmit;
         mscc_pkg::BkEmit:   if (fire) begin
            if (rest != 4'h0) st_in = mscc_pkg::BkDiv;
            else if (job.frame_end) st_in = mscc_pkg::BkClose;
            else st_in = mscc_pkg::BkIdle;
         end
         mscc_pkg::BkClose:  if (fire) st_in = mscc_pkg::BkIdle;
         default:            st_in = mscc_pkg::BkIdle;
      endcase
   end

   // Outputs and datapath control
   always_comb begin
      rsp_valid = 1'b0; kind = mscc_pkg::KindLine; xo = '0; yo = '0; lst = 1'b0;
      job_pop = 1'b0; div_start = 1'b0; idx_in = idx_ff; left_in = left_ff;
      case (st_ff)
         mscc_pkg::BkOrigin: begin
            left_in = job.mask;
            idx_in = job.mask[0] ? 2'd0 : job.mask[1] ? 2'd1 : job.mask[2] ? 2'd2 : 2'd3;
            job_pop = !job.active && !job.frame_end;
         end
         mscc_pkg::BkMove: begin
            rsp_valid = 1'b1; kind = mscc_pkg::KindMove; xo = tx_ff; yo = ty_ff;
         end
         mscc_pkg::BkDiv: div_start = !t_direct && (st_in == st_ff) && !div_busy_q;
         mscc_pkg::BkEmit: begin
            rsp_valid = 1'b1;
            case (idx_ff)
               2'd0: begin xo = tx_ff + mscc_pkg::PosW'(off_ff); yo = ty_ff; end
               2'd1: begin
                  xo = tx_ff + mscc_pkg::PosW'(cell_width);
                  yo = ty_ff + mscc_pkg::PosW'(off_ff);
               end
               2'd2: begin
                  xo = tx_ff + mscc_pkg::PosW'(cell_width) - mscc_pkg::PosW'(off_ff);
                  yo = ty_ff + mscc_pkg::PosW'(cell_height);
               end
               default: begin
                  xo = tx_ff;
                  yo = ty_ff + mscc_pkg::PosW'(cell_height) - mscc_pkg::PosW'(off_ff);
               end
            endcase
            lst = (rest == 4'h0) && !job.frame_end;
            if (fire) begin
               left_in = rest;
               idx_in = rest[0] ? 2'd0 : rest[1] ? 2'd1 : rest[2] ? 2'd2 : 2'd3;
               job_pop = lst;
            end
         end
         mscc_pkg::BkClose: begin
            rsp_valid = 1'b1; kind = mscc_pkg::KindClose; lst = 1'b1; job_pop = fire;
         end
         default: ;
      endcase
   end

   // Track whether the divider has been launched for this edge
   assign div_busy_q = div_busy_ff;
   always_comb begin
      div_busy_in = div_busy_ff;
      if (div_start) div_busy_in = 1'b1;
      if (div_done || st_ff != mscc_pkg::BkDiv) div_busy_in = 1'b0;
   end

   mscc_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(num[mscc_pkg::ValW:0]), .den(diff[mscc_pkg::ValW:0]),
      .done(div_done), .quo(div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= mscc_pkg::BkIdle; div_busy_ff <= 1'b0;
      end else begin
         st_ff <= st_in; div_busy_ff <= div_busy_in;
      end
      idx_ff <= idx_in; left_ff <= left_in;
      if (st_ff == mscc_pkg::BkOrigin) begin
         tx_ff <= mscc_pkg::PosW'(job.cx) * mscc_pkg::PosW'(cell_width);
         ty_ff <= mscc_pkg::PosW'(job.cy) * mscc_pkg::PosW'(cell_height);
      end
      if (st_ff == mscc_pkg::BkDiv) t_ff <= t_direct ? t_fix : {1'b0, div_q};
      if (st_ff == mscc_pkg::BkScale) off_ff <= prod[31:16];
   end

   assign rsp_point_kind = kind;
   assign rsp_x_pos = xo;
   assign rsp_y_pos = yo;
   assign rsp_last = lst;

   property p_pop_last;
      @(posedge clock) disable iff (reset) job_pop && job.active |-> fire && rsp_last;
   endproperty
   a_pop_last: assert property (p_pop_last) else $error("job retired without last");
   property p_close_zero;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_point_kind == mscc_pkg::KindClose |-> rsp_x_pos == 0 && rsp_y_pos == 0;
   endproperty
   a_close_zero: assert property (p_close_zero) else $error("close carries position");
   property p_div_in_state;
      @(posedge clock) disable iff (reset) div_done |-> st_ff == mscc_pkg::BkDiv;
   endproperty
   a_div_in_state: assert property (p_div_in_state) else $error("divider result lost");
endmodule

/* src/marching_squares_cell_contour.sv */
// Top level of the marching-squares cell contour block.
//  Channel  | Direction | Handshake          | Carries
//  req_     | in        | valid / stall      | cell position, corners, frame marks
//  rsp_     | out       | valid / stall      | point kind, position, last
//  csr_     | in        | valid / ready      | register index, write data
// A cell is loaded in the origin state; a move point adds the move state, each inside
// corner the divide, scale and emit states (the shared one-bit-a-cycle divider runs
// unless the crossing is trivial), and a close the close state. A two-entry queue lets
// cells be accepted while the back end works. Reset is synchronous; registers
// return to 2.5 px cells. Result stalls hold the back end; a full queue stalls req_.
module marching_squares_cell_contour (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [mscc_pkg::CoordW-1:0]      req_cell_x,
   input  logic [mscc_pkg::CoordW-1:0]      req_cell_y,
   input  logic signed [mscc_pkg::ValW-1:0] req_v_top_left,
   input  logic signed [mscc_pkg::ValW-1:0] req_v_top_right,
   input  logic signed [mscc_pkg::ValW-1:0] req_v_bottom_right,
   input  logic signed [mscc_pkg::ValW-1:0] req_v_bottom_left,
   input  logic                             req_frame_start,
   input  logic                             req_frame_end,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_point_kind,
   output logic [mscc_pkg::PosW-1:0]        rsp_x_pos,
   output logic [mscc_pkg::PosW-1:0]        rsp_y_pos,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_index,
   input  logic [mscc_pkg::SizeW-1:0]       csr_data
);
   logic [mscc_pkg::SizeW-1:0] width_ff, height_ff;
   logic job_valid, job_pop;
   mscc_pkg::job_type job;

   assign csr_ready = 1'b1;

   // Hold the cell size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 16'd640; height_ff <= 16'd640;
      end else if (csr_valid) begin
         if (csr_index == mscc_pkg::CsrWidth) width_ff <= csr_data;
         else height_ff <= csr_data;
      end
   end

   mscc_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_cell_x(req_cell_x), .req_cell_y(req_cell_y),
      .req_v_top_left(req_v_top_left), .req_v_top_right(req_v_top_right),
      .req_v_bottom_right(req_v_bottom_right), .req_v_bottom_left(req_v_bottom_left),
      .req_frame_start(req_frame_start), .req_frame_end(req_frame_end),
      .job_valid(job_valid), .job(job), .job_pop(job_pop)
   );

   mscc_back u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job(job), .job_pop(job_pop),
      .cell_width(width_ff), .cell_height(height_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_point_kind(rsp_point_kind),
      .rsp_x_pos(rsp_x_pos), .rsp_y_pos(rsp_y_pos), .rsp_last(rsp_last)
   );
endmodule
